// ===== sv/rles_pkg.sv =====
// ----------------------------------------------------------------------------
// rles_pkg
// Shared types, constants and style helpers of the RGB LED effect sequencer.
// ----------------------------------------------------------------------------
package rles_pkg;

	localparam int WIDTH_W    = 16;
	localparam int RAND_W     = 8;
	localparam int LEVEL_W    = 13;
	localparam int COUNT_W    = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int S_DATA_W   = 24;
	localparam int M_DATA_W   = 56;

	localparam logic [CFG_IDX_W-1:0] REG_EFFECT_MODE     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_MINIMUM = 1'd1;

	localparam logic [15:0] DIM_LEVEL       = 16'h0032;
	localparam logic [15:0] BRIGHT_A        = 16'hFE00;
	localparam logic [15:0] BRIGHT_B        = 16'hFF40;
	localparam logic [15:0] RESET_LEVEL     = 16'h0FFF;
	localparam logic [15:0] INIT_MIN_RESET  = 16'd9000;
	localparam logic [6:0]  FOLLOW_GAIN     = 7'd65;

	localparam logic [15:0] RED_STEP     = 16'd257;
	localparam logic [15:0] GREEN_STEP   = 16'd491;
	localparam logic [15:0] BLUE_STEP    = 16'd107;
	localparam logic [15:0] RED_TOP      = 16'h8000;
	localparam logic [15:0] GREEN_TOP    = 16'h8000;
	localparam logic [15:0] BLUE_TOP     = 16'hFE00;
	localparam logic [15:0] RED_BOTTOM   = 16'd320;
	localparam logic [15:0] GREEN_BOTTOM = 16'd550;
	localparam logic [15:0] BLUE_BOTTOM  = 16'd170;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
		logic        headlight;
	} leds_t;

	typedef struct packed {
		logic        effect_mode;
		logic        reload;
		logic [15:0] initial_minimum;
	} cfg_t;

	typedef struct packed {
		logic        down;
		logic [15:0] level;
	} sweep_t;

	typedef enum logic [3:0] {
		K_DIM, K_WHITE, K_RED, K_GREEN, K_BLUE, K_SWEEP,
		K_CYCLE, K_POLICE, K_STROBE, K_STROBE2, K_RANDOM, K_HOLD
	} kind_t;

	// style = level / 50, grouped into the kinds that share behavior
	function automatic kind_t kind_of(input logic [LEVEL_W-1:0] level);
		kind_t k;
		priority if (level < 13'd50)  k = K_DIM;
		else if (level < 13'd150)     k = K_WHITE;
		else if (level < 13'd200)     k = K_RED;
		else if (level < 13'd250)     k = K_GREEN;
		else if (level < 13'd300)     k = K_BLUE;
		else if (level < 13'd400)     k = K_SWEEP;
		else if (level < 13'd550)     k = K_CYCLE;
		else if (level < 13'd650)     k = K_POLICE;
		else if (level < 13'd750)     k = K_STROBE;
		else if (level < 13'd850)     k = K_STROBE2;
		else if (level < 13'd900)     k = K_RANDOM;
		else                          k = K_HOLD;
		return k;
	endfunction

	function automatic sweep_t sweep_step(input logic [15:0] v, input logic down,
			input logic [15:0] step, input logic [15:0] top, input logic [15:0] bottom);
		sweep_t res;
		res.level = down ? (v - step) : (v + step);
		res.down  = down;
		if (!res.down && res.level > top)
			res.down = 1'b1;
		if (res.down && res.level < bottom)
			res.down = 1'b0;
		return res;
	endfunction

	function automatic logic [15:0] pick(input logic bright, input logic [15:0] on_level);
		return bright ? on_level : DIM_LEVEL;
	endfunction

	// remainders by 3, 5 and 7 via reciprocal multiply, exact for 8-bit values
	function automatic leds_t rand_leds(input logic [RAND_W-1:0] r);
		leds_t       res;
		logic [16:0] p3;
		logic [16:0] p5;
		logic [16:0] p7;
		logic [7:0]  q3;
		logic [7:0]  q5;
		logic [7:0]  q7;
		logic        z3;
		logic        z5;
		logic        z7;
		p3 = {9'd0, r} * 17'd171;
		p5 = {9'd0, r} * 17'd205;
		p7 = {9'd0, r} * 17'd293;
		q3 = 8'(p3 >> 9);
		q5 = 8'(p5 >> 10);
		q7 = 8'(p7 >> 11);
		z3 = (10'({2'd0, q3} * 10'd3) == {2'd0, r});
		z5 = (10'({2'd0, q5} * 10'd5) == {2'd0, r});
		z7 = (10'({2'd0, q7} * 10'd7) == {2'd0, r});
		if (r[0]) begin
			res = '{DIM_LEVEL, DIM_LEVEL, DIM_LEVEL, 1'b0};
		end else begin
			// r even here, so a multiple of 6 is a multiple of 3
			res.red       = pick(r[1:0] == 2'd0, BRIGHT_B);
			res.green     = pick(z5, BRIGHT_B);
			res.blue      = pick(z3, BRIGHT_B);
			res.headlight = z7;
		end
		return res;
	endfunction

endpackage

// ===== sv/rgb_led_effect_sequencer.sv =====
// ----------------------------------------------------------------------------
// rgb_led_effect_sequencer
// RGB LED level and effect sequencer driven by a measured pulse width.
// ----------------------------------------------------------------------------
// Each request on the slave channel carries a pulse width and a random byte;
// each produces exactly one result on the master channel with the three
// colour levels and the headlight state after the update.
// The block tracks a running minimum width and derives level = (w - min) / 8.
// Follow mode drives all colours with 65 * level; effect mode picks a style
// from level / 50 (dim, white, solid colours, sweep, cycle, police, strobes,
// random, or hold).
// An accepted request passes the input register, then the result register,
// before m_tvalid rises; a receiver stall can hold it in the input register.
// Throughput: one request per cycle unless the receiver stalls, set by the
// single update pass between the registers, which also updates the state.
// When the receiver stalls, the result register holds and the input
// register still takes one more request; s_tready drops once both are full.
// Reset: colours 0x0FFF, headlight on, pattern counter and sweep directions
// cleared, follow mode, running minimum 9000. Writing initial_minimum
// reloads the running minimum. Configure only while idle.
// ----------------------------------------------------------------------------
module rgb_led_effect_sequencer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// pulse_width [15:0], random_byte [23:16]
	input  logic [rles_pkg::S_DATA_W-1:0]        s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// red_level [15:0], green_level [31:16], blue_level [47:32],
	// headlight_on [48], zero [55:49]
	output logic [rles_pkg::M_DATA_W-1:0]        m_tdata,
	input  logic                                 cfg_we,
	input  logic [rles_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rles_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

	logic                           valid_s1;
	logic [rles_pkg::WIDTH_W-1:0]   pulse_width_s1;
	logic [rles_pkg::RAND_W-1:0]    random_byte_s1;
	logic                           advance;
	logic                           effect_mode_q;
	rles_pkg::cfg_t                 cfg;
	rles_pkg::leds_t                leds_next;

	// move the held request forward when the result slot is free or draining
	assign advance = valid_s1 && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			effect_mode_q <= 1'b0;
		end else if (cfg_we && cfg_index == rles_pkg::REG_EFFECT_MODE) begin
			effect_mode_q <= cfg_wdata[0];
		end
	end

	assign cfg.effect_mode     = effect_mode_q;
	assign cfg.reload          = cfg_we && cfg_index == rles_pkg::REG_INITIAL_MINIMUM;
	assign cfg.initial_minimum = cfg_wdata;

	rles_in_reg u_in (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.advance        (advance),
		.valid_s1       (valid_s1),
		.pulse_width_s1 (pulse_width_s1),
		.random_byte_s1 (random_byte_s1)
	);

	rles_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.pulse_width (pulse_width_s1),
		.random_byte (random_byte_s1),
		.cfg         (cfg),
		.leds_next   (leds_next)
	);

	rles_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.leds     (leds_next),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== sv/rles_in_reg.sv =====
// ----------------------------------------------------------------------------
// rles_in_reg
// Input register stage: captures one request from the slave channel.
// ----------------------------------------------------------------------------
module rles_in_reg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// pulse_width [15:0], random_byte [23:16]
	input  logic [rles_pkg::S_DATA_W-1:0]         s_tdata,
	input  logic                                  advance,
	output logic                                  valid_s1,
	output logic [rles_pkg::WIDTH_W-1:0]          pulse_width_s1,
	output logic [rles_pkg::RAND_W-1:0]           random_byte_s1
);

	logic load;

	assign s_tready = !valid_s1 || advance;
	assign load     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pulse_width_s1 <= s_tdata[15:0];
			random_byte_s1 <= s_tdata[23:16];
		end
	end

endmodule

// ===== sv/rles_core.sv =====
// ----------------------------------------------------------------------------
// rles_core
// Calibration, level computation and effect styles with their state registers.
// ----------------------------------------------------------------------------
module rles_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  logic [rles_pkg::WIDTH_W-1:0]   pulse_width,
	input  logic [rles_pkg::RAND_W-1:0]    random_byte,
	input  rles_pkg::cfg_t                 cfg,
	output rles_pkg::leds_t                leds_next
);

	rles_pkg::leds_t                  leds_q;
	logic [rles_pkg::COUNT_W-1:0]     pattern_q;
	logic [2:0]                       down_q;
	logic [rles_pkg::WIDTH_W-1:0]     min_q;

	logic [rles_pkg::WIDTH_W-1:0]     min_eff;
	logic [rles_pkg::WIDTH_W-1:0]     diff;
	logic [rles_pkg::LEVEL_W-1:0]     level;
	logic [19:0]                      follow_prod;
	rles_pkg::kind_t                  kind;
	logic [rles_pkg::COUNT_W-1:0]     c;
	logic [rles_pkg::COUNT_W-1:0]     c_inc;
	logic [rles_pkg::COUNT_W-1:0]     pattern_next;
	logic [2:0]                       down_next;
	rles_pkg::sweep_t                 sw_r;
	rles_pkg::sweep_t                 sw_g;
	rles_pkg::sweep_t                 sw_b;

	assign min_eff     = (pulse_width < min_q) ? pulse_width : min_q;
	assign diff        = pulse_width - min_eff;
	assign level       = diff[15:3];
	assign follow_prod = {7'd0, level} * {13'd0, rles_pkg::FOLLOW_GAIN};
	assign kind        = rles_pkg::kind_of(level);

	assign sw_r = rles_pkg::sweep_step(leds_q.red, down_q[0], rles_pkg::RED_STEP,
		rles_pkg::RED_TOP, rles_pkg::RED_BOTTOM);
	assign sw_g = rles_pkg::sweep_step(leds_q.green, down_q[1], rles_pkg::GREEN_STEP,
		rles_pkg::GREEN_TOP, rles_pkg::GREEN_BOTTOM);
	assign sw_b = rles_pkg::sweep_step(leds_q.blue, down_q[2], rles_pkg::BLUE_STEP,
		rles_pkg::BLUE_TOP, rles_pkg::BLUE_BOTTOM);

	always_comb begin
		leds_next    = leds_q;
		pattern_next = pattern_q;
		down_next    = down_q;
		c            = pattern_q;
		c_inc        = pattern_q + 8'd1;
		if (!cfg.effect_mode) begin
			leds_next.red   = follow_prod[15:0];
			leds_next.green = follow_prod[15:0];
			leds_next.blue  = follow_prod[15:0];
		end else begin
			unique case (kind)
				rles_pkg::K_DIM: begin
					leds_next = '{rles_pkg::DIM_LEVEL, rles_pkg::DIM_LEVEL,
						rles_pkg::DIM_LEVEL, 1'b0};
				end
				rles_pkg::K_WHITE: begin
					leds_next = '{rles_pkg::BRIGHT_A, rles_pkg::BRIGHT_A,
						rles_pkg::BRIGHT_A, 1'b1};
				end
				rles_pkg::K_RED: begin
					leds_next = '{rles_pkg::BRIGHT_A, rles_pkg::DIM_LEVEL,
						rles_pkg::DIM_LEVEL, 1'b0};
				end
				rles_pkg::K_GREEN: begin
					leds_next = '{rles_pkg::DIM_LEVEL, rles_pkg::BRIGHT_A,
						rles_pkg::DIM_LEVEL, 1'b0};
				end
				rles_pkg::K_BLUE: begin
					leds_next = '{rles_pkg::DIM_LEVEL, rles_pkg::DIM_LEVEL,
						rles_pkg::BRIGHT_A, 1'b0};
				end
				rles_pkg::K_SWEEP: begin
					leds_next.red   = sw_r.level;
					leds_next.green = sw_g.level;
					leds_next.blue  = sw_b.level;
					down_next       = {sw_b.down, sw_g.down, sw_r.down};
				end
				rles_pkg::K_CYCLE: begin
					if (pattern_q > 8'd127)
						c = '0;
					leds_next.red       = rles_pkg::pick(c[4], rles_pkg::BRIGHT_A);
					leds_next.green     = rles_pkg::pick(c[6], rles_pkg::BRIGHT_A);
					leds_next.blue      = rles_pkg::pick(c[5], rles_pkg::BRIGHT_A);
					leds_next.headlight = 1'b0;
					pattern_next        = c + 8'd1;
				end
				rles_pkg::K_POLICE: begin
					if (c == 8'd0 || c == 8'd6) begin
						leds_next.red   = rles_pkg::BRIGHT_A;
						leds_next.green = rles_pkg::DIM_LEVEL;
						leds_next.blue  = rles_pkg::DIM_LEVEL;
					end
					if (c == 8'd4 || c == 8'd10 || c == 8'd28 || c == 8'd34) begin
						leds_next.red   = rles_pkg::DIM_LEVEL;
						leds_next.green = rles_pkg::DIM_LEVEL;
						leds_next.blue  = rles_pkg::DIM_LEVEL;
					end
					if (c == 8'd24 || c == 8'd30) begin
						leds_next.red   = rles_pkg::DIM_LEVEL;
						leds_next.green = rles_pkg::DIM_LEVEL;
						leds_next.blue  = rles_pkg::BRIGHT_A;
					end
					pattern_next = (c_inc > 8'd48) ? 8'd0 : c_inc;
				end
				rles_pkg::K_STROBE: begin
					if (pattern_q > 8'd3)
						c = '0;
					if (c == 8'd0)
						leds_next = '{rles_pkg::BRIGHT_B, rles_pkg::BRIGHT_B,
							rles_pkg::BRIGHT_B, 1'b1};
					else
						leds_next = '{rles_pkg::DIM_LEVEL, rles_pkg::DIM_LEVEL,
							rles_pkg::DIM_LEVEL, 1'b0};
					pattern_next = c + 8'd1;
				end
				rles_pkg::K_STROBE2: begin
					if (pattern_q > 8'd15)
						c = '0;
					leds_next = '{rles_pkg::DIM_LEVEL, rles_pkg::DIM_LEVEL,
						rles_pkg::DIM_LEVEL, 1'b0};
					if (c == 8'd0)
						leds_next = '{rles_pkg::BRIGHT_B, rles_pkg::BRIGHT_B,
							rles_pkg::BRIGHT_B, 1'b1};
					else if (c == 8'd4)
						leds_next.blue = rles_pkg::BRIGHT_B;
					else if (c == 8'd8)
						leds_next.red = rles_pkg::BRIGHT_B;
					else if (c == 8'd12)
						leds_next.green = rles_pkg::BRIGHT_B;
					pattern_next = c + 8'd1;
				end
				rles_pkg::K_RANDOM: begin
					leds_next = rles_pkg::rand_leds(random_byte);
				end
				default: begin
					// styles above the random one hold everything
					leds_next = leds_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leds_q    <= '{rles_pkg::RESET_LEVEL, rles_pkg::RESET_LEVEL,
				rles_pkg::RESET_LEVEL, 1'b1};
			pattern_q <= '0;
			down_q    <= '0;
			min_q     <= rles_pkg::INIT_MIN_RESET;
		end else begin
			if (cfg.reload) begin
				min_q <= cfg.initial_minimum;
			end else if (fire) begin
				min_q <= min_eff;
			end
			if (fire) begin
				leds_q    <= leds_next;
				pattern_q <= pattern_next;
				down_q    <= down_next;
			end
		end
	end

endmodule

// ===== sv/rles_out_reg.sv =====
// ----------------------------------------------------------------------------
// rles_out_reg
// Result register: holds one result until the master channel takes it.
// ----------------------------------------------------------------------------
module rles_out_reg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  rles_pkg::leds_t                    leds,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// red_level [15:0], green_level [31:16], blue_level [47:32],
	// headlight_on [48], zero [55:49]
	output logic [rles_pkg::M_DATA_W-1:0]      m_tdata
);

	logic            valid_s2;
	rles_pkg::leds_t leds_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			leds_s2 <= leds;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, leds_s2.headlight, leds_s2.blue, leds_s2.green, leds_s2.red};

endmodule

// ===== sv/rles_checker.sv =====
// ----------------------------------------------------------------------------
// rles_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module rles_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [rles_pkg::M_DATA_W-1:0]        m_tdata
);

	// a stalled result holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// back-pressure only while a result is waiting and stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input blocked without output stall");

	// every accepted request shows a result after the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("result missing after request");

	// padding bits of the result stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[55:49] == 7'd0)
		else $error("result padding not zero");

endmodule

bind rgb_led_effect_sequencer rles_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the RGB LED effect sequencer.
// ----------------------------------------------------------------------------
// A class tracks the colour, headlight, pattern counter, sweep direction and
// running minimum state. Every accepted request updates that state, and the
// resulting levels are queued. Each result is compared with the oldest
// queued levels. Requests come in bursts with random gaps. The result side
// stalls in patterns that are picked anew at random during the run. Both modes are
// covered under several starting minimums. Effect phases aim at one style
// at a time in long runs, with stray widths mixed in.
// ----------------------------------------------------------------------------
module testbench;

	class led_sequence_board;
		bit              effect_on;
		logic [15:0]     start_min;
		logic [15:0]     red;
		logic [15:0]     green;
		logic [15:0]     blue;
		logic            lamp;
		logic [7:0]      count;
		bit              falling [3];
		logic [15:0]     min_w;
		rles_pkg::leds_t pending_levels [$];
		int              errors;

		function new();
			effect_on = 1'b0;
			start_min = rles_pkg::INIT_MIN_RESET;
			red       = rles_pkg::RESET_LEVEL;
			green     = rles_pkg::RESET_LEVEL;
			blue      = rles_pkg::RESET_LEVEL;
			lamp      = 1'b1;
			count     = 8'd0;
			falling   = '{0, 0, 0};
			min_w     = rles_pkg::INIT_MIN_RESET;
			errors    = 0;
		endfunction

		function void write_reg(logic [rles_pkg::CFG_IDX_W-1:0] idx,
				logic [rles_pkg::CFG_DATA_W-1:0] val);
			case (idx)
				rles_pkg::REG_EFFECT_MODE: effect_on = val[0];
				rles_pkg::REG_INITIAL_MINIMUM: begin
					start_min = val;
					min_w     = val;
				end
				default: ;
			endcase
		endfunction

		function void paint(logic [15:0] r, logic [15:0] g, logic [15:0] b, logic h);
			red   = r;
			green = g;
			blue  = b;
			lamp  = h;
		endfunction

		function logic [15:0] sweep(logic [15:0] v, int ch, logic [15:0] step,
				logic [15:0] top, logic [15:0] bottom);
			logic [15:0] nv;
			nv = falling[ch] ? v - step : v + step;
			if (!falling[ch] && nv > top)
				falling[ch] = 1'b1;
			if (falling[ch] && nv < bottom)
				falling[ch] = 1'b0;
			return nv;
		endfunction

		function rles_pkg::kind_t style_kind(int unsigned s);
			case (s)
				0:        return rles_pkg::K_DIM;
				1, 2:     return rles_pkg::K_WHITE;
				3:        return rles_pkg::K_RED;
				4:        return rles_pkg::K_GREEN;
				5:        return rles_pkg::K_BLUE;
				6, 7:     return rles_pkg::K_SWEEP;
				8, 9, 10: return rles_pkg::K_CYCLE;
				11, 12:   return rles_pkg::K_POLICE;
				13, 14:   return rles_pkg::K_STROBE;
				15, 16:   return rles_pkg::K_STROBE2;
				17:       return rles_pkg::K_RANDOM;
				default:  return rles_pkg::K_HOLD;
			endcase
		endfunction

		function void run_style(rles_pkg::kind_t k, logic [7:0] r);
			logic [7:0] c;
			c = count;
			case (k)
				rles_pkg::K_DIM: paint(rles_pkg::DIM_LEVEL, rles_pkg::DIM_LEVEL,
					rles_pkg::DIM_LEVEL, 1'b0);
				rles_pkg::K_WHITE: paint(rles_pkg::BRIGHT_A, rles_pkg::BRIGHT_A,
					rles_pkg::BRIGHT_A, 1'b1);
				rles_pkg::K_RED: paint(rles_pkg::BRIGHT_A, rles_pkg::DIM_LEVEL,
					rles_pkg::DIM_LEVEL, 1'b0);
				rles_pkg::K_GREEN: paint(rles_pkg::DIM_LEVEL, rles_pkg::BRIGHT_A,
					rles_pkg::DIM_LEVEL, 1'b0);
				rles_pkg::K_BLUE: paint(rles_pkg::DIM_LEVEL, rles_pkg::DIM_LEVEL,
					rles_pkg::BRIGHT_A, 1'b0);
				rles_pkg::K_SWEEP: begin
					blue  = sweep(blue, 2, rles_pkg::BLUE_STEP, rles_pkg::BLUE_TOP,
						rles_pkg::BLUE_BOTTOM);
					red   = sweep(red, 0, rles_pkg::RED_STEP, rles_pkg::RED_TOP,
						rles_pkg::RED_BOTTOM);
					green = sweep(green, 1, rles_pkg::GREEN_STEP, rles_pkg::GREEN_TOP,
						rles_pkg::GREEN_BOTTOM);
				end
				rles_pkg::K_CYCLE: begin
					if (c > 8'd127)
						c = 8'd0;
					paint(c[4] ? rles_pkg::BRIGHT_A : rles_pkg::DIM_LEVEL,
						c[6] ? rles_pkg::BRIGHT_A : rles_pkg::DIM_LEVEL,
						c[5] ? rles_pkg::BRIGHT_A : rles_pkg::DIM_LEVEL, 1'b0);
					count = c + 8'd1;
				end
				rles_pkg::K_POLICE: begin
					if (c == 8'd0 || c == 8'd6)
						paint(rles_pkg::BRIGHT_A, rles_pkg::DIM_LEVEL,
							rles_pkg::DIM_LEVEL, lamp);
					else if (c == 8'd4 || c == 8'd10 || c == 8'd28 || c == 8'd34)
						paint(rles_pkg::DIM_LEVEL, rles_pkg::DIM_LEVEL,
							rles_pkg::DIM_LEVEL, lamp);
					else if (c == 8'd24 || c == 8'd30)
						paint(rles_pkg::DIM_LEVEL, rles_pkg::DIM_LEVEL,
							rles_pkg::BRIGHT_A, lamp);
					count = c + 8'd1;
					if (count > 8'd48)
						count = 8'd0;
				end
				rles_pkg::K_STROBE: begin
					if (c > 8'd3)
						c = 8'd0;
					if (c == 8'd0)
						paint(rles_pkg::BRIGHT_B, rles_pkg::BRIGHT_B,
							rles_pkg::BRIGHT_B, 1'b1);
					else
						paint(rles_pkg::DIM_LEVEL, rles_pkg::DIM_LEVEL,
							rles_pkg::DIM_LEVEL, 1'b0);
					count = c + 8'd1;
				end
				rles_pkg::K_STROBE2: begin
					if (c > 8'd15)
						c = 8'd0;
					if (c == 8'd0)
						paint(rles_pkg::BRIGHT_B, rles_pkg::BRIGHT_B,
							rles_pkg::BRIGHT_B, 1'b1);
					else if (c == 8'd4)
						paint(rles_pkg::DIM_LEVEL, rles_pkg::DIM_LEVEL,
							rles_pkg::BRIGHT_B, 1'b0);
					else if (c == 8'd8)
						paint(rles_pkg::BRIGHT_B, rles_pkg::DIM_LEVEL,
							rles_pkg::DIM_LEVEL, 1'b0);
					else if (c == 8'd12)
						paint(rles_pkg::DIM_LEVEL, rles_pkg::BRIGHT_B,
							rles_pkg::DIM_LEVEL, 1'b0);
					else
						paint(rles_pkg::DIM_LEVEL, rles_pkg::DIM_LEVEL,
							rles_pkg::DIM_LEVEL, 1'b0);
					count = c + 8'd1;
				end
				rles_pkg::K_RANDOM: begin
					if (r[0])
						paint(rles_pkg::DIM_LEVEL, rles_pkg::DIM_LEVEL,
							rles_pkg::DIM_LEVEL, 1'b0);
					else
						paint((r % 4 == 0) ? rles_pkg::BRIGHT_B : rles_pkg::DIM_LEVEL,
							(r % 5 == 0) ? rles_pkg::BRIGHT_B : rles_pkg::DIM_LEVEL,
							(r % 6 == 0) ? rles_pkg::BRIGHT_B : rles_pkg::DIM_LEVEL,
							r % 7 == 0);
				end
				default: ;
			endcase
		endfunction

		// one accepted request: update the state and queue the levels it leaves
		function void take_pulse(logic [15:0] w, logic [7:0] r);
			logic [15:0]     lvl;
			rles_pkg::leds_t want;
			if (w < min_w)
				min_w = w;
			lvl = (w - min_w) >> 3;
			if (!effect_on) begin
				red   = lvl * 16'd65;
				green = red;
				blue  = red;
			end else begin
				run_style(style_kind(lvl / 50), r);
			end
			want.red       = red;
			want.green     = green;
			want.blue      = blue;
			want.headlight = lamp;
			pending_levels.push_back(want);
		endfunction

		function int pending();
			return pending_levels.size();
		endfunction

		function void compare_channel(string label, logic [15:0] want, logic [15:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
				errors++;
			end
		endfunction

		function void check_levels(logic [rles_pkg::M_DATA_W-1:0] data);
			rles_pkg::leds_t want;
			if (pending_levels.size() == 0) begin
				$display("%0t: result with no request outstanding, expected none, actual %h",
					$time, data);
				errors++;
				return;
			end
			want = pending_levels.pop_front();
			compare_channel("red", want.red, data[15:0]);
			compare_channel("green", want.green, data[31:16]);
			compare_channel("blue", want.blue, data[47:32]);
			compare_channel("headlight", {15'd0, want.headlight}, {15'd0, data[48]});
		endfunction
	endclass

	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_ITEMS = 185;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [rles_pkg::S_DATA_W-1:0]   s_tdata   = '0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [rles_pkg::M_DATA_W-1:0]   m_tdata;
	logic                            cfg_we    = 1'b0;
	logic [rles_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [rles_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	led_sequence_board sb = new();

	int burst_left   = 0;
	int quiet_cycles = 0;
	int recv_tick    = 0;
	int recv_mode    = 0;
	int recv_hold    = 0;

	rgb_led_effect_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	// result side: check, stall pattern, watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_levels(m_tdata);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
				$display("Simulation FAILED");
				$finish;
			end
			recv_tick++;
			if (recv_tick % 250 == 0)
				recv_mode = $urandom_range(0, 3);
			case (recv_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (recv_tick % 5 == 0);
				default: begin
					if (recv_hold == 0) begin
						m_tready <= ~m_tready;
						recv_hold = $urandom_range(1, 20);
					end else begin
						recv_hold--;
					end
				end
			endcase
		end
	end

	task automatic send_item(logic [15:0] w, logic [7:0] r);
		if (burst_left == 0)
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
		s_tdata  <= {r, w};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		sb.take_pulse(w, r);
		burst_left--;
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	// stop sending and wait until every queued result has come back
	task automatic settle();
		if (s_tvalid)
			s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	task automatic set_config(logic mode, logic [15:0] min_start);
		logic [rles_pkg::CFG_DATA_W-1:0] mode_word;
		mode_word = {15'($urandom), mode};
		cfg_we    <= 1'b1;
		cfg_index <= rles_pkg::REG_EFFECT_MODE;
		cfg_wdata <= mode_word;
		@(posedge clk);
		sb.write_reg(rles_pkg::REG_EFFECT_MODE, mode_word);
		cfg_index <= rles_pkg::REG_INITIAL_MINIMUM;
		cfg_wdata <= min_start;
		@(posedge clk);
		sb.write_reg(rles_pkg::REG_INITIAL_MINIMUM, min_start);
		cfg_we <= 1'b0;
	endtask

	// width that lands in effect style s given the current running minimum
	function automatic logic [15:0] aim_width(int s);
		int unsigned target;
		target = sb.min_w + 400 * s + 8 * $urandom_range(0, 49) + $urandom_range(0, 7);
		if (target > 65535)
			return 16'($urandom);
		return 16'(target);
	endfunction

	initial begin
		int          phase;
		int          n;
		int          s;
		int          run;
		int          i;
		int          choice;
		int unsigned near;
		logic        mode;
		logic [15:0] min_start;
		logic [15:0] w;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// follow mode from reset: at the minimum, full scale, recalibration to zero
		send_item(16'd9000, 8'h00);
		send_item(16'hFFFF, 8'hFF);
		send_item(16'd9007, 8'h55);
		send_item(16'd0, 8'hAA);

		// each effect style at one end of its band (even low, odd high), minimum at zero
		settle();
		set_config(1'b1, 16'd0);
		for (s = 0; s < 18; s++)
			send_item(16'(400 * s + ((s % 2) ? 399 : 0)), 8'($urandom));
		send_item(16'd6800, 8'd0);
		send_item(16'd6808, 8'd210);
		send_item(16'd6816, 8'd255);
		send_item(16'd7200, 8'($urandom));
		send_item(16'hFFFF, 8'($urandom));

		for (phase = 0; phase < 10; phase++) begin
			settle();
			mode = phase[0];
			case (phase)
				0: min_start = 16'd0;
				1: min_start = 16'd0;
				2: min_start = 16'hFFFF;
				3: min_start = 16'hFFFF;
				4: min_start = rles_pkg::INIT_MIN_RESET;
				default: min_start = ($urandom_range(0, 1)) ? 16'($urandom)
					: 16'($urandom_range(0, 2000));
			endcase
			set_config(mode, min_start);
			n = 0;
			while (n < PHASE_ITEMS) begin
				if (mode) begin
					choice = $urandom_range(0, 99);
					if (choice < 25) begin
						s   = $urandom_range(6, 7);
						run = $urandom_range(40, 200);
					end else if (choice < 35) begin
						s   = $urandom_range(8, 10);
						run = $urandom_range(20, 140);
					end else if (choice < 45) begin
						s   = $urandom_range(11, 12);
						run = $urandom_range(10, 60);
					end else if (choice < 85) begin
						s   = $urandom_range(0, 17);
						run = $urandom_range(1, 20);
					end else if (choice < 92) begin
						s   = $urandom_range(18, 163);
						run = $urandom_range(1, 5);
					end else begin
						s   = -1;
						run = $urandom_range(1, 4);
					end
				end else begin
					s   = -2;
					run = $urandom_range(1, 30);
				end
				for (i = 0; i < run && n < PHASE_ITEMS; i++) begin
					if (s >= 0) begin
						w = aim_width(s);
					end else if (s == -1 || $urandom_range(0, 1)) begin
						w = 16'($urandom);
					end else begin
						near = sb.min_w + $urandom_range(0, 2000);
						w = (near > 65535) ? 16'hFFFF : 16'(near);
					end
					send_item(w, 8'($urandom));
					n++;
					// hold off mid-phase until the pipeline has fully drained
					if (n == PHASE_ITEMS / 2 && phase[1])
						settle();
				end
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/rles_pkg.sv
sv/rles_in_reg.sv
sv/rles_core.sv
sv/rles_out_reg.sv
sv/rgb_led_effect_sequencer.sv
sv/rles_checker.sv
bench/testbench.sv
